FILE: rtl/core/vt4_pkg.sv
// Package: widths, payload types, register map and reset values for the vertex transform.
`timescale 1ns / 1ps
`default_nettype none

package vt4_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int NUM_ROWS  = 4;
   localparam int NUM_COLS  = 4;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int ACC_W     = PROD_W + 2;
   localparam int SHIFT_W   = ACC_W - FRAC_BITS;
   localparam int REG_W     = 64;
   localparam int NUM_REGS  = 8;
   localparam int IDX_W     = $clog2(NUM_REGS);
   localparam int BYTE_W    = $clog2(REG_W / 8);
   localparam int ADDR_W    = IDX_W + BYTE_W;
   localparam int LANE_LAT  = 4;

   localparam logic [DATA_W-1:0] Q_ONE = DATA_W'(1) << FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [IDX_W-1:0] {
      REG_ROW0_AB,
      REG_ROW0_CD,
      REG_ROW1_AB,
      REG_ROW1_CD,
      REG_ROW2_AB,
      REG_ROW2_CD,
      REG_ROW3_AB,
      REG_ROW3_CD
   } reg_idx_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] in_x;
      logic signed [DATA_W-1:0] in_y;
      logic signed [DATA_W-1:0] in_z;
      logic signed [DATA_W-1:0] in_w;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_x;
      logic signed [DATA_W-1:0] out_y;
      logic signed [DATA_W-1:0] out_z;
      logic signed [DATA_W-1:0] out_w;
      logic                     overflow;
   } rsp_type;

   typedef logic [NUM_COLS-1:0][DATA_W-1:0] row_coef_type;
   typedef row_coef_type [NUM_ROWS-1:0] matrix_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result;
      logic                     ovf;
   } lane_out_type;

   function automatic logic [REG_W-1:0] reg_reset_value(input reg_idx_type idx);
      logic [REG_W-1:0] val;
      unique case (idx)
         REG_ROW0_AB: val = {{DATA_W{1'b0}}, Q_ONE};
         REG_ROW1_AB: val = {Q_ONE, {DATA_W{1'b0}}};
         REG_ROW2_CD: val = {{DATA_W{1'b0}}, Q_ONE};
         REG_ROW3_CD: val = {Q_ONE, {DATA_W{1'b0}}};
         default:     val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/vertex_transform_4x4.sv
// Top level: 4x4 matrix times vertex, one lane per row plus a merging output stage.
// Throughput: one transaction per cycle; busy is never raised, the four row lanes are
// fully pipelined (multiply, pair add, final add with rounding, saturate, merge).
// Reset: synchronous, active high; matrix returns to identity, in-flight results dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_4x4 (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output      logic                        busy,
   input  wire vt4_pkg::req_type            req_data,
   output      logic                        rsp_valid,
   output      vt4_pkg::rsp_type            rsp_data,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [vt4_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [vt4_pkg::REG_W-1:0]   pwdata,
   output      logic [vt4_pkg::REG_W-1:0]   prdata,
   output      logic                        pready
);
   import vt4_pkg::*;

   matrix_type            matrix;
   row_coef_type          vec;
   lane_out_type          lane_out [NUM_ROWS];
   logic [LANE_LAT-1:0]   vld_ff;
   logic [LANE_LAT-1:0]   vld_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_in;
   rsp_type               rsp_data_ff;

   assign busy = 1'b0;
   assign vec  = {req_data.in_w, req_data.in_z, req_data.in_y, req_data.in_x};

   vt4_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .matrix  (matrix)
   );

   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
      vt4_lane u_lane (
         .clock    (clock),
         .coef     (matrix[r]),
         .vec      (vec),
         .lane_out (lane_out[r])
      );
   end

   assign vld_in = {vld_ff[LANE_LAT-2:0], start && !busy};

   always_comb begin
      rsp_in.out_x    = lane_out[0].result;
      rsp_in.out_y    = lane_out[1].result;
      rsp_in.out_z    = lane_out[2].result;
      rsp_in.out_w    = lane_out[3].result;
      rsp_in.overflow = lane_out[0].ovf || lane_out[1].ovf ||
                        lane_out[2].ovf || lane_out[3].ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[LANE_LAT-1];
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/vt4_csr.sv
// Matrix register file behind the APB-style configuration port.
`timescale 1ns / 1ps
`default_nettype none

module vt4_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [vt4_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [vt4_pkg::REG_W-1:0]   pwdata,
   output      logic [vt4_pkg::REG_W-1:0]   prdata,
   output      logic                        pready,
   output      vt4_pkg::matrix_type         matrix
);
   import vt4_pkg::*;

   logic [REG_W-1:0] regs_ff [NUM_REGS];
   logic [IDX_W-1:0] idx;
   logic             wr_en;

   assign pready = 1'b1;
   assign idx    = paddr[ADDR_W-1:BYTE_W];
   assign wr_en  = psel && penable && pwrite && pready;
   assign prdata = regs_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= reg_reset_value(reg_idx_type'(IDX_W'(i)));
         end
      end else if (wr_en) begin
         regs_ff[idx] <= pwdata;
      end
   end

   // two coefficients per register, lower column in the low half
   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
      for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
         assign matrix[r][c] = regs_ff[r * 2 + c / 2][(c % 2) * DATA_W +: DATA_W];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/vt4_lane.sv
// One row lane: four products, adder tree, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module vt4_lane (
   input  wire logic                   clock,
   input  wire vt4_pkg::row_coef_type  coef,
   input  wire vt4_pkg::row_coef_type  vec,
   output      vt4_pkg::lane_out_type  lane_out
);
   import vt4_pkg::*;

   logic signed [DATA_W-1:0]  coef_s [NUM_COLS];
   logic signed [DATA_W-1:0]  vec_s  [NUM_COLS];
   logic signed [PROD_W-1:0]  prod_in [NUM_COLS];
   logic signed [PROD_W-1:0]  prod_ff [NUM_COLS];
   logic signed [PAIR_W-1:0]  pair_in [2];
   logic signed [PAIR_W-1:0]  pair_ff [2];
   logic signed [ACC_W-1:0]   sum_in;
   logic signed [ACC_W-1:0]   sum_ff;
   logic [SHIFT_W-1:0]        shifted;
   logic [SHIFT_W-DATA_W:0]   hi_bits;
   lane_out_type              out_in;
   lane_out_type              out_ff;

   always_comb begin
      for (int c = 0; c < NUM_COLS; c++) begin
         coef_s[c]  = coef[c];
         vec_s[c]   = vec[c];
         prod_in[c] = coef_s[c] * vec_s[c];
      end
   end

   always_comb begin
      pair_in[0] = PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
      pair_in[1] = PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);
      sum_in     = ACC_W'(pair_ff[0]) + ACC_W'(pair_ff[1]) + ROUND_HALF;
   end

   always_comb begin
      shifted    = sum_ff[ACC_W-1:FRAC_BITS];
      hi_bits    = shifted[SHIFT_W-1:DATA_W-1];
      out_in.ovf = !((&hi_bits) || (~|hi_bits));
      if (!out_in.ovf) begin
         out_in.result = shifted[DATA_W-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         out_in.result = SAT_MIN;
      end else begin
         out_in.result = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_COLS; c++) begin
         prod_ff[c] <= prod_in[c];
      end
      pair_ff[0] <= pair_in[0];
      pair_ff[1] <= pair_in[1];
      sum_ff     <= sum_in;
      out_ff     <= out_in;
   end

   assign lane_out = out_ff;

endmodule

`default_nettype wire

FILE: sim/vertex_transform_4x4_tb.sv
// Testbench: random and directed vertex transactions against a fixed point matrix predictor.
`timescale 1ns / 1ps

module vertex_transform_4x4_tb;
   import vt4_pkg::*;

   localparam int PIPE_DEPTH    = 5;
   localparam int WATCHDOG_MAX  = 5000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 86;

   class vertex_scoreboard;
      logic [REG_W-1:0] coef_regs [NUM_REGS];
      rsp_type          expected_q [$];
      int               errors;

      function new();
         foreach (coef_regs[i]) coef_regs[i] = '0;
         coef_regs[REG_ROW0_AB] = REG_W'(Q_ONE);
         coef_regs[REG_ROW1_AB] = REG_W'(Q_ONE) << DATA_W;
         coef_regs[REG_ROW2_CD] = REG_W'(Q_ONE);
         coef_regs[REG_ROW3_CD] = REG_W'(Q_ONE) << DATA_W;
         errors = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%t: %s", $time, msg);
      endfunction

      function void load_coefs(int idx, logic [REG_W-1:0] val);
         coef_regs[idx] = val;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // row dot vector, round half up at the binary point, clamp to 32 bits
      function rsp_type transform(req_type v);
         logic signed [DATA_W-1:0] vec [NUM_COLS];
         logic signed [DATA_W-1:0] lanes [NUM_ROWS];
         logic signed [DATA_W-1:0] c;
         logic signed [67:0]       acc, cw, vw;
         rsp_type                  r;
         vec = '{v.in_x, v.in_y, v.in_z, v.in_w};
         r = '0;
         for (int row = 0; row < NUM_ROWS; row++) begin
            acc = 68'sd1 <<< (FRAC_BITS - 1);
            for (int col = 0; col < NUM_COLS; col++) begin
               c = coef_regs[row * 2 + col / 2][(col % 2) * DATA_W +: DATA_W];
               cw = c;
               vw = vec[col];
               acc = acc + cw * vw;
            end
            acc = acc >>> FRAC_BITS;
            if (acc > SAT_MAX) begin
               acc = SAT_MAX;
               r.overflow = 1'b1;
            end else if (acc < SAT_MIN) begin
               acc = SAT_MIN;
               r.overflow = 1'b1;
            end
            lanes[row] = acc[DATA_W-1:0];
         end
         r.out_x = lanes[0];
         r.out_y = lanes[1];
         r.out_z = lanes[2];
         r.out_w = lanes[3];
         return r;
      endfunction

      function void note_vertex(req_type v);
         expected_q.push_back(transform(v));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            flag($sformatf("unexpected transaction %h", got));
            return;
         end
         want = expected_q.pop_front();
         if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
             got.out_z !== want.out_z || got.out_w !== want.out_w ||
             got.overflow !== want.overflow)
            flag($sformatf({"transaction: exp x=%h y=%h z=%h w=%h ovf=%b",
                            " got x=%h y=%h z=%h w=%h ovf=%b"},
                           want.out_x, want.out_y, want.out_z, want.out_w, want.overflow,
                           got.out_x, got.out_y, got.out_z, got.out_w, got.overflow));
      endfunction

      function void check_register(int idx, logic [REG_W-1:0] got);
         if (got !== coef_regs[idx])
            flag($sformatf("csr %0d: exp %h got %h", idx, coef_regs[idx], got));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [REG_W-1:0]    pwdata;
   logic [REG_W-1:0]    prdata;
   logic                pready;
   int                  idle_cycles = 0;

   vertex_scoreboard sb = new();

   vertex_transform_4x4 u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   always @(negedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_vertex(input req_type v);
      req_data <= v;
      start    <= 1'b1;
      do @(negedge clock); while (busy);
      @(posedge clock);
      sb.note_vertex(v);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 3) @(posedge clock);
   endtask

   task automatic csr_write(input int idx, input logic [REG_W-1:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(idx) << BYTE_W;
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.load_coefs(idx, val);
   endtask

   task automatic csr_verify(input int idx);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_W'(idx) << BYTE_W;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      sb.check_register(idx, prdata);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic req_type vertex_of(input logic [DATA_W-1:0] x, y, z, w);
      req_type v;
      v.in_x = x;
      v.in_y = y;
      v.in_z = z;
      v.in_w = w;
      return v;
   endfunction

   function automatic logic [DATA_W-1:0] extreme_value();
      case ($urandom_range(0, 5))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return 32'h1;
         4:       return '1;
         default: return Q_ONE;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] small_value(input int bits);
      return $urandom_range(0, (1 << (bits + 1)) - 1) - (1 << bits);
   endfunction

   function automatic logic [DATA_W-1:0] random_coef(input int style);
      case (style)
         0:       return small_value(17);
         1:       return $urandom;
         default: return $urandom_range(0, 1) ? extreme_value() : small_value(17);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] random_component();
      int                kind;
      logic [DATA_W-1:0] half;
      kind = $urandom_range(0, 9);
      if (kind < 6) return small_value(23);
      if (kind < 8) return $urandom;
      if (kind == 8) return extreme_value();
      half = ($urandom_range(0, 63) << FRAC_BITS) | 32'h8000;
      return $urandom_range(0, 1) ? -half : half;
   endfunction

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int   style;
      logic burst;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // identity matrix out of reset
      send_vertex(vertex_of(32'h0, 32'h0, 32'h0, 32'h0));
      send_vertex(vertex_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF));
      send_vertex(vertex_of(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1));
      send_vertex(vertex_of(Q_ONE, 32'h1234_5678, 32'hDEAD_BEEF, 32'h8000_0001));
      drain();
      for (int i = 0; i < NUM_REGS; i++) csr_verify(i);

      // tiny +/- coefficient for rounding ties, full-scale rows for clamping
      csr_write(REG_ROW0_AB, {32'h0, 32'h1});
      csr_write(REG_ROW0_CD, '0);
      csr_write(REG_ROW1_AB, {32'h0, 32'hFFFF_FFFF});
      csr_write(REG_ROW1_CD, '0);
      csr_write(REG_ROW2_AB, {2{32'h7FFF_FFFF}});
      csr_write(REG_ROW2_CD, {2{32'h7FFF_FFFF}});
      csr_write(REG_ROW3_AB, {2{32'h8000_0000}});
      csr_write(REG_ROW3_CD, {2{32'h8000_0000}});
      send_vertex(vertex_of(32'h8000, 32'h0, 32'h0, 32'h0));
      send_vertex(vertex_of(32'hFFFF_8000, 32'h0, 32'h0, 32'h0));
      send_vertex(vertex_of(32'h1_8000, 32'h0, 32'h0, 32'h0));
      send_vertex(vertex_of(32'hFFFE_8000, 32'h0, 32'h0, 32'h0));
      send_vertex(vertex_of(32'h7FFF, 32'h0, 32'h0, 32'h0));
      send_vertex(vertex_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_vertex(vertex_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_vertex(vertex_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      send_vertex(vertex_of(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF));
      send_vertex(vertex_of(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0));
      send_vertex(vertex_of(32'h1, 32'h1, 32'h1, 32'h1));
      send_vertex(vertex_of(32'h2_0000, 32'h0, 32'hFFFF_0000, 32'h1_0000));
      send_vertex(vertex_of(32'h0, 32'h0, 32'h0, 32'h0));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         style = phase % 3;
         for (int i = 0; i < NUM_REGS; i++)
            csr_write(i, {random_coef(style), random_coef(style)});
         for (int i = 0; i < NUM_REGS; i++) csr_verify(i);
         burst = (phase % 3 == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_vertex(vertex_of(random_component(), random_component(),
                                  random_component(), random_component()));
            if (!burst) idle_sender(random_gap());
         end
      end

      drain();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
